// ===== rtl/sma_pkg.sv =====
// shared constants and types for the simple moving average block
// no dependencies; imported by sma_div, simple_moving_average and tb_top
package sma_pkg;

   localparam int DATA_W         = 32;
   localparam int WLEN_W         = 9;
   localparam int WINDOW_MAX_DEF = 256;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd20;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/simple_moving_average.sv =====
// simple moving average over a ring of price samples held in one memory
// the bit-serial divider sets the pace: one sample is taken at a time, and the next sample
// is taken only once the previous average is in the rsp register, where it may still wait
// synchronous reset clears fill count, write index, running sum and sets window to 20
// ring memory is not cleared; entries are only read after being written
module simple_moving_average import sma_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WLEN_W-1:0] csr_window_length,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_close_price,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_average
);

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = DATA_W + IDX_W;
   localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
   localparam int OFS_W = CNT_W + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DATA_W-1:0] sample_ff, sample_in;
   logic              drop_ff, drop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] avg_ff, avg_in;

   logic [DATA_W-1:0] ring [WINDOW_MAX];
   logic [DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  old_idx;
   logic [IDX_W-1:0]  wr_idx_ff;
   logic              wr_en;
   logic              rd_en;

   logic [LEN_W-1:0]  wlen_ext;
   logic [CNT_W-1:0]  len_eff;
   logic [OFS_W-1:0]  ofs_raw;
   logic [OFS_W-1:0]  ofs_wrap;
   logic              req_xfer;
   logic              rsp_free;
   logic              div_start;
   logic [SUM_W-1:0]  div_quo;
   div_status_type    div_stat;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // effective window: zero counts as one, saturate at the ring depth
   assign wlen_ext = LEN_W'(wlen_ff);
   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (wlen_ext > LEN_W'(WINDOW_MAX)) begin
         len_eff = CNT_W'(WINDOW_MAX);
      end else begin
         len_eff = wlen_ext[CNT_W-1:0];
      end
   end

   // oldest slot = write index minus fill count, modulo the ring depth
   assign ofs_raw  = OFS_W'(widx_ff) + OFS_W'(WINDOW_MAX) - OFS_W'(fill_ff);
   assign ofs_wrap = (ofs_raw >= OFS_W'(WINDOW_MAX)) ? ofs_raw - OFS_W'(WINDOW_MAX)
                                                     : ofs_raw;
   assign old_idx  = ofs_wrap[IDX_W-1:0];

   // read of the oldest sample happens in the transfer cycle, write in the cycle after it (S_READ)
   assign rd_en     = req_xfer;
   assign wr_en     = (state_ff == S_READ);
   assign div_start = (state_ff == S_READ);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wr_idx_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring[old_idx];
      end
   end

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      widx_in      = widx_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;

      if (csr_valid && csr_ready) begin
         wlen_in = csr_window_length;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = req_close_price;
               if (fill_ff < len_eff) begin
                  fill_in = fill_ff + 1'b1;
                  drop_in = 1'b0;
               end else begin
                  drop_in = 1'b1;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            sum_in = sum_ff - (drop_ff ? SUM_W'(rd_data_ff) : '0) + SUM_W'(sample_ff);
            widx_in = (widx_ff == IDX_W'(WINDOW_MAX - 1)) ? '0 : widx_ff + 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               avg_in       = div_quo[DATA_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= WLEN_RESET;
         widx_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      drop_ff   <= drop_in;
      avg_ff    <= avg_in;
      wr_idx_ff <= (state_ff == S_IDLE) ? widx_ff : wr_idx_ff;
   end

   sma_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_ff),
      .quotient (div_quo),
      .status   (div_stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;

   property p_fill_bounded;
      @(posedge clock) disable iff (reset) fill_ff <= CNT_W'(WINDOW_MAX);
   endproperty
   a_fill_bounded: assert property (p_fill_bounded)
      else $error("fill count above ring depth");

   property p_widx_bounded;
      @(posedge clock) disable iff (reset) OFS_W'(widx_ff) < OFS_W'(WINDOW_MAX);
   endproperty
   a_widx_bounded: assert property (p_widx_bounded)
      else $error("write index outside ring");

   property p_xfer_to_read;
      @(posedge clock) disable iff (reset) req_xfer |=> (state_ff == S_READ);
   endproperty
   a_xfer_to_read: assert property (p_xfer_to_read)
      else $error("sample transfer not followed by memory access");

   property p_div_nonzero_count;
      @(posedge clock) disable iff (reset) (state_ff == S_DIV) |-> (fill_ff != '0);
   endproperty
   a_div_nonzero_count: assert property (p_div_nonzero_count)
      else $error("averaging with empty window");

endmodule

// ===== rtl/sma_div.sv =====
// restoring divider, one quotient bit per cycle, for the running sum
// depends on sma_pkg (div_status_type)
module sma_div import sma_pkg::*; #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [SUM_W-1:0] quotient,
   output div_status_type   status
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
      end else if (step_ff != '0) begin
         // remainder stays below the divisor, so it fits in CNT_W bits
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (step_ff != '0);
   assign status.done = done_ff;

   property p_no_zero_divisor;
      @(posedge clock) disable iff (reset) status.busy |-> (dvs_ff != '0);
   endproperty
   a_no_zero_divisor: assert property (p_no_zero_divisor)
      else $error("divider running with zero divisor");

   property p_done_after_last_step;
      @(posedge clock) disable iff (reset)
         (status.busy && step_ff == STEP_W'(1) && !start) |=> status.done;
   endproperty
   a_done_after_last_step: assert property (p_done_after_last_step)
      else $error("divider missed its done pulse");

   property p_done_ends_busy;
      @(posedge clock) disable iff (reset) status.done |-> !status.busy || $past(start);
   endproperty
   a_done_ends_busy: assert property (p_done_ends_busy)
      else $error("divider done while still busy");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for simple_moving_average: directed table, then random phases
// depends on rtl/sma_pkg.sv, rtl/sma_div.sv and rtl/simple_moving_average.sv
module tb_top import sma_pkg::*;;

   localparam int WMAX        = WINDOW_MAX_DEF;
   localparam int IDX_W       = $clog2(WMAX);
   localparam int SUM_W       = DATA_W + IDX_W;
   localparam int LATENCY     = SUM_W + 3;
   localparam int LONG_HOLD   = 600;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_REPORTS = 10;

   typedef enum bit {ROW_ITEM, ROW_WINDOW} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [WLEN_W-1:0] wlen;
      logic [DATA_W-1:0] price;
      bit                typed;
      logic [DATA_W-1:0] avg;
   } dir_row_type;

   // typed rows are plain: first sample after reset, window of one, two-sample mean
   localparam int NUM_ROWS = 20;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_ITEM,   9'd0,   32'h0000_0100, 1'b1, 32'h0000_0100},
      '{ROW_WINDOW, 9'd0,   32'h0,         1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM,   9'd0,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_ITEM,   9'd0,   32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM,   9'd0,   32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM,   9'd0,   32'h0000_0001, 1'b1, 32'h0000_0001},
      '{ROW_WINDOW, 9'd1,   32'h0,         1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA},
      '{ROW_ITEM,   9'd0,   32'h5555_5555, 1'b1, 32'h5555_5555},
      '{ROW_WINDOW, 9'd511, 32'h0,         1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'hFFFF_FFFF, 1'b1, 32'hAAAA_AAAA},
      '{ROW_ITEM,   9'd0,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'h0000_0000, 1'b0, 32'h0},
      '{ROW_WINDOW, 9'd3,   32'h0,         1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'h1234_5678, 1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'h0000_0000, 1'b0, 32'h0},
      '{ROW_ITEM,   9'd0,   32'h0000_0000, 1'b0, 32'h0}
   };

   // random phases: window setting and sample count, growing first, then shrinking
   localparam int NUM_PHASES = 8;
   localparam int PHASE_LEN   [NUM_PHASES] = '{20, 37, 128, 256, 300, 511, 2, 0};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 150, 200, 400, 150, 200, 250, 250};
   localparam int HOLD_PHASE_A = 3;
   localparam int HOLD_PHASE_B = 6;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [WLEN_W-1:0] csr_window_length = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_close_price = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_average;

   // predicted block state
   logic [DATA_W-1:0] hist_price [WMAX];
   logic [IDX_W-1:0]  hist_wr;
   logic [WLEN_W-1:0] hist_count;
   logic [SUM_W-1:0]  hist_sum;
   logic [WLEN_W-1:0] window_setting;

   logic [DATA_W-1:0] avg_expected_q [$];
   int unsigned       samples_sent;
   int unsigned       averages_checked;
   int unsigned       window_writes;
   int unsigned       mismatches;
   int unsigned       burst_left;

   // receiver state: the stimulus sets initial values and holds_asked, otherwise only the receiver process touches it
   int unsigned       holds_asked;
   int unsigned       holds_served;
   int unsigned       hold_left;
   int unsigned       run_left;
   bit                run_ready;

   simple_moving_average uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_close_price   (req_close_price),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average       (rsp_average)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] next_average(input logic [DATA_W-1:0] price);
      logic [WLEN_W-1:0] span;
      logic [IDX_W-1:0]  oldest;
      logic [SUM_W-1:0]  quotient;
      if (window_setting == '0)
         span = WLEN_W'(1);
      else if (window_setting > WLEN_W'(WMAX))
         span = WLEN_W'(WMAX);
      else
         span = window_setting;
      if (hist_count < span) begin
         hist_count++;
      end else begin
         oldest   = hist_wr - hist_count[IDX_W-1:0];
         hist_sum = hist_sum - SUM_W'(hist_price[oldest]);
      end
      hist_price[hist_wr] = price;
      hist_sum = hist_sum + SUM_W'(price);
      hist_wr++;
      quotient = hist_sum / SUM_W'(hist_count);
      return quotient[DATA_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on average #%0d (%s): expected %h, got %h",
                  averages_checked, what, want, got);
   endtask

   // offer one sample, record its expected average, then maybe idle before the next
   task automatic send_price(input logic [DATA_W-1:0] price, input bit typed,
                             input logic [DATA_W-1:0] typed_avg);
      logic [DATA_W-1:0] predicted;
      int unsigned       gap;
      req_valid       <= 1'b1;
      req_close_price <= price;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = next_average(price);
      avg_expected_q.push_back(typed ? typed_avg : predicted);
      samples_sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 60);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained(input int unsigned settle);
      req_valid <= 1'b0;
      while (avg_expected_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_window(input logic [WLEN_W-1:0] len);
      wait_drained(4);
      csr_valid         <= 1'b1;
      csr_window_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_setting = len;
      window_writes++;
      csr_valid <= 1'b0;
   endtask

   // output side: long hold-offs on request, otherwise alternating runs of ready and stall
   always @(posedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(1, 40) : $urandom_range(1, 70);
            if (run_ready && $urandom_range(0, 5) == 0)
               run_left = 400;
         end
         run_left--;
         rsp_ready <= run_ready;
      end
   end

   always @(posedge clock) begin : check_average
      logic [DATA_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         averages_checked++;
         if (avg_expected_q.size() == 0) begin
            report_mismatch("no sample pending", 'x, rsp_average);
         end else begin
            want = avg_expected_q.pop_front();
            if (rsp_average !== want)
               report_mismatch("average", want, rsp_average);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL simple_moving_average");
      $finish;
   end

   initial begin : stimulus
      int unsigned       pick;
      logic [DATA_W-1:0] price;
      holds_asked    = 0;
      holds_served   = 0;
      hold_left      = 0;
      run_left       = 0;
      run_ready      = 1'b0;
      burst_left     = 0;
      hist_wr        = '0;
      hist_count     = '0;
      hist_sum       = '0;
      window_setting = WLEN_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_WINDOW)
            write_window(DIRECTED[i].wlen);
         else
            send_price(DIRECTED[i].price, DIRECTED[i].typed, DIRECTED[i].avg);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_window(WLEN_W'(PHASE_LEN[p]));
         // stall the output while samples keep coming so the input backs up
         if (p == HOLD_PHASE_A || p == HOLD_PHASE_B)
            holds_asked <= holds_asked + 1;
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0, 1:    price = '1;
               2:       price = '0;
               3:       price = $urandom | 32'hFF00_0000;
               default: price = $urandom;
            endcase
            send_price(price, 1'b0, '0);
         end
      end

      wait_drained(LATENCY);
      $display("checked %0d averages from %0d samples over %0d window writes",
               averages_checked, samples_sent, window_writes);
      $display("final fill %0d, including saturated, zero and shrinking windows",
               hist_count);
      if (mismatches == 0) begin
         $display("PASS simple_moving_average");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL simple_moving_average");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sma_pkg.sv
rtl/sma_div.sv
rtl/simple_moving_average.sv
dv/tb_top.sv
